// File: rtl/prwb_pkg.sv
// Package: field widths, beat types, register codes and the rounding helper.
package prwb_pkg;

  localparam int COORD_W   = 24;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 14;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int TAG_W     = 8;
  localparam int INDEX_W   = 16;
  localparam int PROD_W    = COORD_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

  localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h4000_0000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [TAG_W-1:0]          type_tag;
    logic                      frame_end;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rot_x;
    logic signed [COORD_W-1:0] rot_y;
    logic signed [COORD_W-1:0] rot_z;
    logic [TAG_W-1:0]          type_out;
    logic [INDEX_W-1:0]        point_index;
    logic signed [COORD_W-1:0] lowest_x;
    logic [COORD_W-2:0]        highest_x;
    logic signed [COORD_W-1:0] lowest_y;
    logic [COORD_W-2:0]        highest_y;
    logic signed [COORD_W-1:0] lowest_z;
    logic [COORD_W-2:0]        highest_z;
    logic                      frame_last;
  } point_out_t;

  typedef logic signed [PROD_W-1:0] prod_t;

  // Sum of three products, floored by the Q1.14 shift, saturated to a coordinate.
  function automatic logic signed [COORD_W-1:0] row_result(input prod_t p0,
                                                           input prod_t p1,
                                                           input prod_t p2);
    logic signed [SUM_W-1:0]           sum;
    logic signed [SUM_W-COEF_FRAC-1:0] q;
    logic                              fits;
    sum  = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
    // dropping the low bits of a two's complement value floors it
    q    = sum[SUM_W-1:COEF_FRAC];
    fits = (q[SUM_W-COEF_FRAC-1:COORD_W-1] == '0) ||
           (q[SUM_W-COEF_FRAC-1:COORD_W-1] == '1);
    if (fits) begin
      row_result = q[COORD_W-1:0];
    end else if (q[SUM_W-COEF_FRAC-1]) begin
      row_result = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      row_result = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/point_rotate_with_bounds.sv
// Top level: 3x3 point rotation with per-frame running bounding box.
//
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  points   | pt_valid, pt_ready, pt_data (point_in_t)  | in
//  results  | res_valid, res_ready, res_data            | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_wdata| in
//
// One point per cycle sustained while results are taken; a taken beat passes
// through the input register (loaded on the accepting edge), then the product
// register, then the result register.
// The nine products sit in their own register stage; sum, floor, saturate
// and the bounds update share the last stage.
// rst clears all valids, the index, the bounds and loads the identity matrix.
// A stall at the result holds full stages only; pt_ready drops only if all are full.
module point_rotate_with_bounds
  import prwb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pt_valid,
  output logic                 pt_ready,
  input  point_in_t            pt_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output point_out_t           res_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_wdata
);

  logic [ROW_W-1:0] row_x, row_y, row_z;

  // input register
  logic      a_valid;
  point_in_t a_data;

  // product register
  logic             b_valid;
  prod_t            prod [3][3];
  prod_t            prod_next [3][3];
  logic [TAG_W-1:0] b_tag;
  logic             b_last;

  // frame state
  logic [INDEX_W-1:0]        index_count;
  logic signed [COORD_W-1:0] min_x, min_y, min_z;
  logic [COORD_W-2:0]        max_x, max_y, max_z;

  logic out_free, b_free;
  logic signed [COORD_W-1:0] rx, ry, rz;
  logic signed [COORD_W-1:0] min_x_next, min_y_next, min_z_next;
  logic [COORD_W-2:0]        max_x_next, max_y_next, max_z_next;

  logic [ROW_W-1:0]          rows   [3];
  logic signed [COORD_W-1:0] coords [3];

  assign cfg_ready = 1'b1;
  assign out_free  = !res_valid || res_ready;
  assign b_free    = !b_valid || out_free;
  assign pt_ready  = !a_valid || b_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= ROW_X_RESET;
      row_y <= ROW_Y_RESET;
      row_z <= ROW_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_X: row_x <= cfg_wdata;
        REG_ROW_Y: row_y <= cfg_wdata;
        REG_ROW_Z: row_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pt_ready) begin
      a_valid <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_valid && pt_ready) begin
      a_data <= pt_data;
    end
  end

  always_comb begin
    rows[0]   = row_x;
    rows[1]   = row_y;
    rows[2]   = row_z;
    coords[0] = a_data.point_x;
    coords[1] = a_data.point_y;
    coords[2] = a_data.point_z;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_next[r][c] = $signed(rows[r][COEF_W*c +: COEF_W]) * coords[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_free) begin
      prod   <= prod_next;
      b_tag  <= a_data.type_tag;
      b_last <= a_data.frame_end;
    end
  end

  always_comb begin
    rx = row_result(prod[0][0], prod[0][1], prod[0][2]);
    ry = row_result(prod[1][0], prod[1][1], prod[1][2]);
    rz = row_result(prod[2][0], prod[2][1], prod[2][2]);
    min_x_next = (rx < min_x) ? rx : min_x;
    min_y_next = (ry < min_y) ? ry : min_y;
    min_z_next = (rz < min_z) ? rz : min_z;
    max_x_next = (rx > $signed({1'b0, max_x})) ? rx[COORD_W-2:0] : max_x;
    max_y_next = (ry > $signed({1'b0, max_y})) ? ry[COORD_W-2:0] : max_y;
    max_z_next = (rz > $signed({1'b0, max_z})) ? rz[COORD_W-2:0] : max_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      index_count <= '0;
      min_x       <= '0;
      min_y       <= '0;
      min_z       <= '0;
      max_x       <= '0;
      max_y       <= '0;
      max_z       <= '0;
    end else begin
      if (out_free) begin
        res_valid <= b_valid;
      end
      if (b_valid && out_free) begin
        if (b_last) begin
          // end of frame: next beat starts a fresh box at the origin
          index_count <= '0;
          min_x       <= '0;
          min_y       <= '0;
          min_z       <= '0;
          max_x       <= '0;
          max_y       <= '0;
          max_z       <= '0;
        end else begin
          index_count <= index_count + 1'b1;
          min_x       <= min_x_next;
          min_y       <= min_y_next;
          min_z       <= min_z_next;
          max_x       <= max_x_next;
          max_y       <= max_y_next;
          max_z       <= max_z_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && out_free) begin
      res_data.rot_x       <= rx;
      res_data.rot_y       <= ry;
      res_data.rot_z       <= rz;
      res_data.type_out    <= b_tag;
      res_data.point_index <= index_count;
      res_data.lowest_x    <= min_x_next;
      res_data.highest_x   <= max_x_next;
      res_data.lowest_y    <= min_y_next;
      res_data.highest_y   <= max_y_next;
      res_data.lowest_z    <= min_z_next;
      res_data.highest_z   <= max_z_next;
      res_data.frame_last  <= b_last;
    end
  end

  a_box_holds_point: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      ($signed(res_data.lowest_x) <= $signed(res_data.rot_x)) &&
      ($signed({1'b0, res_data.highest_x}) >= $signed(res_data.rot_x)) &&
      ($signed(res_data.lowest_y) <= $signed(res_data.rot_y)) &&
      ($signed({1'b0, res_data.highest_y}) >= $signed(res_data.rot_y)) &&
      ($signed(res_data.lowest_z) <= $signed(res_data.rot_z)) &&
      ($signed({1'b0, res_data.highest_z}) >= $signed(res_data.rot_z)))
    else $error("bounding box does not contain the rotated point");

  a_box_holds_origin: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.lowest_x[COORD_W-1] || (res_data.lowest_x == '0)) &&
                  (res_data.lowest_y[COORD_W-1] || (res_data.lowest_y == '0)) &&
                  (res_data.lowest_z[COORD_W-1] || (res_data.lowest_z == '0)))
    else $error("lower bound above origin");

  a_ready_with_room: assert property (@(posedge clk) disable iff (rst)
    (!a_valid || !b_valid || !res_valid) |-> pt_ready)
    else $error("input stalled while the pipe has a free stage");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (b_valid && out_free && b_last) |=> (index_count == '0) && (max_x == '0))
    else $error("frame state not cleared after last beat");

endmodule

// File: sim/point_rotate_with_bounds_tb.sv
// Testbench for point_rotate_with_bounds: random and directed points checked against a predictor.
`timescale 1ns / 100ps

module point_rotate_with_bounds_tb;
  import prwb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind this index
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam int IDLE_PCT = 17;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 pt_valid = 1'b0;
  logic                 pt_ready;
  point_in_t            pt_data = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  point_out_t           res_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_wdata = '0;

  point_rotate_with_bounds u_dut (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt_data   (pt_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predictor state
  logic [ROW_W-1:0]          coef_row [3] = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};
  logic signed [COORD_W-1:0] box_lo [3] = '{default: '0};
  logic signed [COORD_W-1:0] box_hi [3] = '{default: '0};
  logic [INDEX_W-1:0]        frame_pos = '0;

  point_in_t  point_backlog [$];
  point_out_t rot_expect_q [$];
  int         beats_queued = 0;
  int         beats_taken = 0;
  int         err_count = 0;
  logic       pt_taken = 1'b0;
  logic       steady_flow = 1'b0;

  function automatic logic signed [COORD_W-1:0] apply_row(
      input logic [ROW_W-1:0] row, input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z);
    logic signed [COEF_W-1:0] c0, c1, c2;
    longint acc, q;
    c0 = row[0*COEF_W +: COEF_W];
    c1 = row[1*COEF_W +: COEF_W];
    c2 = row[2*COEF_W +: COEF_W];
    acc = longint'(c0) * longint'(x) + longint'(c1) * longint'(y) + longint'(c2) * longint'(z);
    q = acc >>> COEF_FRAC;  // arithmetic shift floors
    if (q > longint'(C_MAX)) q = longint'(C_MAX);
    if (q < longint'(C_MIN)) q = longint'(C_MIN);
    return q[COORD_W-1:0];
  endfunction

  function automatic point_out_t predict_rotation(input point_in_t p);
    point_out_t r;
    logic signed [COORD_W-1:0] v [3];
    for (int a = 0; a < 3; a++) begin
      v[a] = apply_row(coef_row[a], p.point_x, p.point_y, p.point_z);
      if (v[a] < box_lo[a]) box_lo[a] = v[a];
      if (v[a] > box_hi[a]) box_hi[a] = v[a];
    end
    r.rot_x       = v[0];
    r.rot_y       = v[1];
    r.rot_z       = v[2];
    r.type_out    = p.type_tag;
    r.point_index = frame_pos;
    r.lowest_x    = box_lo[0];
    r.highest_x   = box_hi[0][COORD_W-2:0];
    r.lowest_y    = box_lo[1];
    r.highest_y   = box_hi[1][COORD_W-2:0];
    r.lowest_z    = box_lo[2];
    r.highest_z   = box_hi[2][COORD_W-2:0];
    r.frame_last  = p.frame_end;
    if (p.frame_end) begin
      frame_pos = '0;
      box_lo = '{default: '0};
      box_hi = '{default: '0};
    end else begin
      frame_pos++;  // 16 bits, wraps on its own
    end
    return r;
  endfunction

  task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  task automatic check_result(input point_out_t want, input point_out_t got);
    cmp("rot_x", want.rot_x, got.rot_x);
    cmp("rot_y", want.rot_y, got.rot_y);
    cmp("rot_z", want.rot_z, got.rot_z);
    cmp("type_out", want.type_out, got.type_out);
    cmp("point_index", want.point_index, got.point_index);
    cmp("lowest_x", want.lowest_x, got.lowest_x);
    cmp("highest_x", want.highest_x, got.highest_x);
    cmp("lowest_y", want.lowest_y, got.lowest_y);
    cmp("highest_y", want.highest_y, got.highest_y);
    cmp("lowest_z", want.lowest_z, got.lowest_z);
    cmp("highest_z", want.highest_z, got.highest_z);
    cmp("frame_last", want.frame_last, got.frame_last);
  endtask

  // driver: point channel and result backpressure
  always @(negedge clk) begin
    if (rst) begin
      pt_valid  <= 1'b0;
      res_ready <= 1'b0;
    end else begin
      if (!pt_valid || pt_taken) begin
        if (point_backlog.size() > 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          pt_data  <= point_backlog.pop_front();
          pt_valid <= 1'b1;
        end else begin
          pt_valid <= 1'b0;
        end
      end
      res_ready <= steady_flow || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin
    point_out_t want;
    if (rst) begin
      pt_taken <= 1'b0;
    end else begin
      pt_taken <= pt_valid && pt_ready;
      if (pt_valid && pt_ready) begin
        rot_expect_q.push_back(predict_rotation(pt_data));
        beats_taken++;
      end
      if (res_valid && res_ready) begin
        if (rot_expect_q.size() == 0) begin
          err_count++;
          $error("result beat with nothing expected: rot_x %0h", res_data.rot_x);
        end else begin
          want = rot_expect_q.pop_front();
          check_result(want, res_data);
        end
      end
    end
  end

  function automatic point_in_t mk_point(input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input logic signed [COORD_W-1:0] z,
                                         input logic [TAG_W-1:0] tag, input logic last);
    point_in_t p;
    p.point_x   = x;
    p.point_y   = y;
    p.point_z   = z;
    p.type_tag  = tag;
    p.frame_end = last;
    return p;
  endfunction

  function automatic void send(input point_in_t p);
    point_backlog.push_back(p);
    beats_queued++;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3:    return COORD_W'($urandom_range(2000) - 1000);
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic point_in_t random_point(input bit may_end);
    return mk_point(pick_coord(), pick_coord(), pick_coord(), TAG_W'($urandom()),
                    may_end && $urandom_range(15) == 0);
  endfunction

  // half of the rows keep every coefficient within +-1.0, like a real rotation
  function automatic logic [ROW_W-1:0] pick_row();
    logic [ROW_W-1:0] r;
    r = ROW_W'({$urandom(), $urandom()});
    if ($urandom_range(1))
      for (int c = 0; c < 3; c++)
        r[c*COEF_W +: COEF_W] = COEF_W'($urandom_range(32768) - 16384);
    return r;
  endfunction

  task automatic write_row(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROW_X: coef_row[0] = val;
      REG_ROW_Y: coef_row[1] = val;
      REG_ROW_Z: coef_row[2] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_matrix(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                              input logic [ROW_W-1:0] rz);
    write_row(REG_ROW_X, rx);
    write_row(REG_ROW_Y, ry);
    write_row(REG_ROW_Z, rz);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (beats_taken != beats_queued || rot_expect_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity matrix straight out of reset
    @(posedge clk);
    send(mk_point('0, '0, '0, 8'h00, 1'b0));
    send(mk_point(C_MAX, C_MIN, '0, 8'hFF, 1'b0));
    send(mk_point(C_MIN, C_MAX, COORD_W'(-1), 8'hAA, 1'b0));
    send(mk_point(COORD_W'(1), COORD_W'(-1), C_MAX, 8'h55, 1'b1));
    send(mk_point(COORD_W'(-1), COORD_W'(-1), COORD_W'(-1), 8'h01, 1'b0));
    send(mk_point(C_MIN, C_MIN, C_MIN, 8'h80, 1'b1));

    // extreme coefficients, saturating sums included, plus a write to the unused index
    wait_drained();
    write_matrix(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF);
    write_row(REG_SPARE, 48'h0001_0001_0001);
    @(posedge clk);
    send(mk_point(C_MAX, C_MAX, C_MAX, 8'h0F, 1'b0));
    send(mk_point(C_MIN, C_MIN, C_MIN, 8'hF0, 1'b0));
    send(mk_point(C_MAX, C_MIN, '0, 8'h3C, 1'b0));
    send(mk_point('0, '0, '0, 8'hC3, 1'b1));
    send(mk_point(C_MIN, '0, '0, 8'h5A, 1'b0));
    send(mk_point(COORD_W'(-3), COORD_W'(7), COORD_W'(-16383), 8'hA5, 1'b1));

    // zero row, -1.0 on x, and sums of three unit terms
    wait_drained();
    write_matrix('0, 48'h0000_0000_C000, 48'h4000_4000_4000);
    @(posedge clk);
    send(mk_point(C_MIN, C_MAX, C_MAX, 8'h11, 1'b0));
    send(mk_point(C_MAX, COORD_W'(1), COORD_W'(-1), 8'h22, 1'b0));
    send(mk_point(COORD_W'(-1), '0, '0, 8'h44, 1'b1));

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_matrix(pick_row(), pick_row(), pick_row());
      @(posedge clk);
      steady_flow = (ph == 3);  // one stretch with no idling on either side
      repeat (80) send(random_point(1'b1));
    end

    wait_drained();
    write_matrix(ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET);
    @(posedge clk);
    steady_flow = 1'b0;
    repeat (20) send(random_point(1'b1));

    wait_drained();
    repeat (8) @(negedge clk);
    if (err_count == 0 && rot_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
